FILE: rtl/charset_string_counter_unit_defines.svh
// ----------------------------------------------------------------------------
// Charset string counter assertion macros
// Shared property forms for the concurrent checks of the counter unit.
// ----------------------------------------------------------------------------
`ifndef CHARSET_STRING_COUNTER_UNIT_DEFINES_SVH
`define CHARSET_STRING_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csc: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csc: next-cycle check failed");

`endif

FILE: rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// Charset string counter package
// Widths, codes and shared types of the counter unit and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

    localparam int unsigned DIGIT_W        = 5;
    localparam int unsigned LEN_W          = 5;
    localparam int unsigned CHAR_W         = 8;
    localparam int unsigned CS_ENTRIES     = 32;
    localparam int unsigned SEEK_W         = 64;
    localparam int unsigned RADIX_W        = 6;
    localparam int unsigned TEXT_CHARS     = 16;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 64;
    localparam int unsigned KIND_W         = 2;
    localparam int unsigned IN_TDATA_W     = 72;
    localparam int unsigned OUT_TDATA_W    = 136;

    localparam int unsigned DEF_MAX_CHARS  = 32;
    localparam int unsigned DEF_MAX_DIGITS = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CS_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CS_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CS_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CS_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX    = 3'd4;

    // Operation kinds of an input item.
    localparam logic [KIND_W-1:0] KIND_INC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SEEK = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP  = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD    = 3'd0,
        CELL_INC     = 3'd1,
        CELL_ZERO    = 3'd2,
        CELL_SCRATCH = 3'd3,
        CELL_COMMIT  = 3'd4
    } t_cell_op;

    typedef logic [CS_ENTRIES-1:0][CHAR_W-1:0] t_charset;

    // Broadcast control for the row of digit cells.
    typedef struct packed {
        t_cell_op             op;
        logic [LEN_W-1:0]     len;
        logic [LEN_W-1:0]     bound;
        logic [DIGIT_W-1:0]   digit;
        logic [DIGIT_W-1:0]   top;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/csc_cell.sv
// ----------------------------------------------------------------------------
// Digit cell
// Holds one digit and one seek scratch digit; passes the roll-over carry on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csc_cell
    import csc_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cell_ctrl          i_ctrl,
    input  wire t_charset            i_charset,
    input  wire logic                i_carry,
    output logic                     o_carry,
    output logic                     o_grow,
    output logic [CHAR_W-1:0]        o_char
);

    localparam logic [LEN_W-1:0] IDX_L = LEN_W'(IDX);

    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic [DIGIT_W-1:0] r_scratch, n_scratch;
    logic               active;
    logic               at_len;
    logic               at_top;

    assign active  = IDX_L < i_ctrl.len;
    assign at_len  = IDX_L == i_ctrl.len;
    assign at_top  = r_digit >= i_ctrl.top;
    assign o_carry = i_carry & active & at_top;
    assign o_grow  = i_carry & at_len;
    assign o_char  = active ? i_charset[r_digit] : '0;

    always_comb begin
        n_digit   = r_digit;
        n_scratch = r_scratch;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INC: begin
                // Every digit below has rolled: roll this one or bump it.
                if (i_carry) begin
                    if (active) begin
                        n_digit = at_top ? '0 : r_digit + DIGIT_W'(1);
                    end else if (at_len) begin
                        n_digit = '0;
                    end
                end
            end
            CELL_ZERO: begin
                if (IDX_L < i_ctrl.bound) begin
                    n_digit = '0;
                end
            end
            CELL_SCRATCH: begin
                if (IDX_L == i_ctrl.bound) begin
                    n_scratch = i_ctrl.digit;
                end
            end
            CELL_COMMIT: begin
                if (IDX_L < i_ctrl.bound) begin
                    n_digit = r_scratch;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scratch <= n_scratch;
    end

endmodule

`default_nettype wire

FILE: rtl/csc_div.sv
// ----------------------------------------------------------------------------
// Seek divider
// Restoring divider of the seek value by the radix, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csc_div
    import csc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SEEK_W-1:0]   i_dividend,
    input  wire logic [RADIX_W-1:0]  i_divisor,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [SEEK_W-1:0]        o_quotient,
    output logic [DIGIT_W-1:0]       o_remainder
);

    localparam int unsigned        CNT_W = $clog2(SEEK_W);
    localparam logic [CNT_W-1:0]   LAST  = CNT_W'(SEEK_W - 1);

    logic [SEEK_W-1:0]  r_quo;
    logic [DIGIT_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [RADIX_W-1:0] trial;
    logic               fits;

    assign trial = {r_rem, r_quo[SEEK_W-1]};
    assign fits  = trial >= i_divisor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[SEEK_W-2:0], fits};
            r_rem <= fits ? DIGIT_W'(trial - i_divisor) : DIGIT_W'(trial);
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

FILE: rtl/charset_string_counter_unit.sv
// Increment, zero and no-op: the result is registered in r_pend and then in
//   the result register; one item per cycle while the result side keeps up.
// Seek: one pass of the restoring divider, one quotient bit a cycle, per
//   produced digit; one seek at a time.
// Reset is synchronous and active low: empty string, all digits zero, the
//   character set zero and the radix one. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Charset string counter unit
// Bijective base-N candidate string generator built as a row of digit cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "charset_string_counter_unit_defines.svh"

module charset_string_counter_unit
    import csc_pkg::*;
#(
    parameter int unsigned MAX_CHARS  = DEF_MAX_CHARS,
    parameter int unsigned MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Input items.
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // tdata, from bit 0: digit_count (5), index (64), zero padding (3).
    input  wire logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: kind (2).
    input  wire logic [KIND_W-1:0]       i_s_axis_tuser,
    // Result items.
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // tdata, from bit 0: text_low (64), text_high (64), text_length (5),
    // zero padding (3).
    output logic [OUT_TDATA_W-1:0]       o_m_axis_tdata,
    // tuser: overflowed (1).
    output logic [0:0]                   o_m_axis_tuser,
    // Configuration writes.
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // The counter state is spread over a row of MAX_DIGITS cells, digit 0 in
    // the first. An increment runs as a carry down the row: a cell passes the
    // carry on only when it is in use and at the top of the set, so the first
    // cell that cannot roll takes the increment and the cell just past the
    // string picks up a new first character when every digit rolled.
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_CHARS);
    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_WAIT = 3'b100
    } t_state;

    // Configuration registers.
    t_charset             r_charset;
    logic [RADIX_W-1:0]   r_radix;

    // Control and sequencing.
    t_state               r_state, n_state;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [SEEK_W-1:0]    r_seek_n, n_seek_n;
    logic [LEN_W-1:0]     r_slen, n_slen;
    logic                 r_pend;
    logic                 r_pend_ovf;

    // Result register.
    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic                   r_m_ovf;

    logic [RADIX_W-1:0]   eff_radix;
    logic [DIGIT_W-1:0]   top_digit;
    logic [KIND_W-1:0]    in_kind;
    logic [LEN_W-1:0]     in_count;
    logic [SEEK_W-1:0]    in_index;
    logic                 s_accept;
    logic                 out_free;
    logic                 pend_set;
    logic                 pend_ovf;
    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [SEEK_W-1:0]    div_quo;
    logic [DIGIT_W-1:0]   div_rem;
    t_cell_ctrl           ctrl;

    logic [MAX_DIGITS:0]                   carry;
    logic [MAX_DIGITS-1:0]                 grow;
    logic [TEXT_CHARS-1:0][CHAR_W-1:0]     text;
    logic                                  inc_ovf;
    logic                                  inc_grow;

    // A radix of zero counts as one, anything above the set size saturates.
    always_comb begin
        if (r_radix == '0) begin
            eff_radix = RADIX_W'(1);
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end
    assign top_digit = DIGIT_W'(eff_radix - RADIX_W'(1));

    assign in_count = i_s_axis_tdata[LEN_W-1:0];
    assign in_index = i_s_axis_tdata[LEN_W +: SEEK_W];
    assign in_kind  = i_s_axis_tuser;

    // A finished result waits in r_pend until the output register is free;
    // a new item may enter in the same cycle that result moves out.
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_pend || out_free);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Row of digit cells; text bytes past the row read as zero.
    assign carry[0] = 1'b1;
    for (genvar g = 0; g < TEXT_CHARS; g++) begin : g_lane
        if (g < MAX_DIGITS) begin : g_cell
            csc_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctrl    (ctrl),
                .i_charset (r_charset),
                .i_carry   (carry[g]),
                .o_carry   (carry[g+1]),
                .o_grow    (grow[g]),
                .o_char    (text[g])
            );
        end else begin : g_blank
            assign text[g] = '0;
        end
    end

    // A carry out of the last cell means a full string of top digits at the
    // maximum length: the increment overflows and nothing changes.
    assign inc_ovf  = carry[MAX_DIGITS];
    assign inc_grow = |grow;

    csc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_seek_n - SEEK_W'(1)),
        .i_divisor   (eff_radix),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Sequencer. A seek peels one digit per pass: subtract one, divide by
    // the radix, park the remainder in the scratch of the cell at the
    // current seek length. Only when the value runs out within MAX_DIGITS
    // are the scratch digits copied into the string, so an overflowing seek
    // leaves the string as it was.
    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_seek_n   = r_seek_n;
        n_slen     = r_slen;
        pend_set   = 1'b0;
        pend_ovf   = 1'b0;
        div_start  = 1'b0;
        ctrl.op    = CELL_HOLD;
        ctrl.len   = r_len;
        ctrl.bound = '0;
        ctrl.digit = div_rem;
        ctrl.top   = top_digit;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_kind)
                        KIND_INC: begin
                            pend_set = 1'b1;
                            if (inc_ovf) begin
                                pend_ovf = 1'b1;
                            end else begin
                                ctrl.op = CELL_INC;
                                if (inc_grow) begin
                                    n_len = r_len + LEN_W'(1);
                                end
                            end
                        end
                        KIND_ZERO: begin
                            pend_set = 1'b1;
                            if (in_count > LEN_MAX) begin
                                pend_ovf = 1'b1;
                            end else begin
                                ctrl.op    = CELL_ZERO;
                                ctrl.bound = in_count;
                                n_len      = in_count;
                            end
                        end
                        KIND_SEEK: begin
                            n_seek_n = in_index;
                            n_slen   = '0;
                            n_state  = ST_STEP;
                        end
                        default: begin
                            pend_set = 1'b1;
                        end
                    endcase
                end
            end
            ST_STEP: begin
                if (r_seek_n == '0 || r_slen == LEN_MAX) begin
                    pend_set = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_seek_n != '0) begin
                        pend_ovf = 1'b1;
                    end else begin
                        ctrl.op    = CELL_COMMIT;
                        ctrl.bound = r_slen;
                        n_len      = r_slen;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (div_done) begin
                    ctrl.op    = CELL_SCRATCH;
                    ctrl.bound = r_slen;
                    n_seek_n   = div_quo;
                    n_slen     = r_slen + LEN_W'(1);
                    n_state    = ST_STEP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration writes; indexes past the radix are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charset <= '0;
            r_radix   <= RADIX_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_CS_0_7:   r_charset[7:0]   <= i_cfg_data;
                REG_CS_8_15:  r_charset[15:8]  <= i_cfg_data;
                REG_CS_16_23: r_charset[23:16] <= i_cfg_data;
                REG_CS_24_31: r_charset[31:24] <= i_cfg_data;
                REG_RADIX:    r_radix          <= i_cfg_data[RADIX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_pend    <= pend_set || (r_pend && !out_free);
            r_m_valid <= (r_pend && out_free) || (r_m_valid && !i_m_axis_tready);
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_seek_n <= n_seek_n;
        r_slen   <= n_slen;
        if (pend_set) begin
            r_pend_ovf <= pend_ovf;
        end
        // The cells still hold the string of the pending result here, even
        // when a new item is taken in the same cycle.
        if (r_pend && out_free) begin
            r_m_data <= {3'b000, r_len, text};
            r_m_ovf  <= r_pend_ovf;
        end
    end

    assign o_m_axis_tvalid   = r_m_valid;
    assign o_m_axis_tdata    = r_m_data;
    assign o_m_axis_tuser[0] = r_m_ovf;

    // The string never grows past the row of cells.
    `CSC_ASSERT_IMP(a_len_in_range, i_clk, i_rst_n, 1'b1, r_len <= LEN_MAX)
    // The divider only runs while the sequencer waits on it.
    `CSC_ASSERT_IMP(a_div_in_wait, i_clk, i_rst_n, div_busy, r_state == ST_WAIT)
    // No result may be pending while a seek is under way.
    `CSC_ASSERT_IMP(a_no_pend_in_seek, i_clk, i_rst_n, r_state != ST_IDLE, !r_pend)
    // An accepted seek starts with an empty scratch string.
    `CSC_ASSERT_NEXT(a_seek_starts, i_clk, i_rst_n, s_accept && in_kind == KIND_SEEK,
                     r_state == ST_STEP && r_slen == '0)

endmodule

`default_nettype wire
